/* src/chained_four_op_calculator_defines.svh */
// Assertion macros used by the calculator controller.
`ifndef CHAINED_FOUR_OP_CALCULATOR_DEFINES_SVH
`define CHAINED_FOUR_OP_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cfc_pkg.sv */
// Shared constants, types and the operator decoder of the chained calculator.
package cfc_pkg;

    // Default word geometry: signed Q16.16
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // ASCII operator bytes
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIVZ    = 3'd1;
    localparam logic [2:0] ST_BADOP   = 3'd2;
    localparam logic [2:0] ST_SAT     = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_BAD
    } op_t;

    // What the current word turns into, chosen by the controller
    typedef enum logic [2:0] {
        RES_START,
        RES_IGNORE,
        RES_BADOP,
        RES_DIVZ,
        RES_ADD,
        RES_SUB,
        RES_MUL,
        RES_DIV
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      fin;
        res_kind_t kind;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic aborted;
        op_t  op;
        logic opnd_zero;
    } dp_stat_t;

    function automatic op_t decode_op(input logic [7:0] c);
        op_t r;
        case (c)
            CH_ADD:  r = OP_ADD;
            CH_SUB:  r = OP_SUB;
            CH_MUL:  r = OP_MUL;
            CH_DIV:  r = OP_DIV;
            default: r = OP_BAD;
        endcase
        return r;
    endfunction

endpackage

/* src/cfc_in_if.sv */
// Input channel: one command word (action, operator byte, operand).
interface cfc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         op_char;
    logic signed [31:0] operand;

    modport source (output valid, action, op_char, operand, input ready);
    modport sink   (input valid, action, op_char, operand, output ready);
endinterface

/* src/cfc_out_if.sv */
// Output channel: one result word (accumulator value and status).
interface cfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

/* src/cfc_dp.sv */
// Datapath: accumulator, operand capture, shift-add multiplier, restoring divider, result reg.
module cfc_dp #(
    parameter int WORD_BITS = cfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfc_pkg::dp_cmd_t   cmd,
    output cfc_pkg::dp_stat_t  stat,
    input  logic               action,
    input  logic [7:0]         op_char,
    input  logic signed [31:0] operand,
    output logic signed [31:0] value,
    output logic [2:0]         status
);

    localparam int W  = WORD_BITS;
    localparam int QW = WORD_BITS + FRAC_BITS;          // dividend / quotient width
    localparam int XW = (2 * W > QW) ? 2 * W : QW;      // shared shift register width

    localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] MAX_64 = $signed((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [63:0] MIN_64 = -MAX_64 - 64'sd1;

    function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // Architectural state
    logic [W-1:0]  acc_reg, acc_next;
    logic          aborted_reg, aborted_next;
    // Captured word
    logic          is_start_reg;
    cfc_pkg::op_t  op_reg;
    logic [W-1:0]  opnd_reg;
    logic          sat_in_reg;
    logic          zero_reg;
    logic          neg_reg;
    logic [W-1:0]  mag_a_reg;
    logic [W-1:0]  mag_b_reg;
    // Iteration registers: h holds partial product high half or the remainder
    logic [W-1:0]  h_reg, h_next;
    logic [XW-1:0] x_reg, x_next;
    // Result register
    logic signed [31:0] value_reg, value_next;
    logic [2:0]         status_reg, status_next;

    // Operand clipped to the word range
    logic signed [63:0] opnd_64;
    logic               in_hi, in_lo;
    logic [W-1:0]       opnd_clip;
    logic [W-1:0]       mag_a_new, mag_b_new;
    cfc_pkg::op_t       op_new;

    assign opnd_64   = 64'(operand);
    assign in_hi     = opnd_64 > MAX_64;
    assign in_lo     = opnd_64 < MIN_64;
    assign opnd_clip = in_hi ? MAX_W : (in_lo ? MIN_W : opnd_64[W-1:0]);
    assign mag_a_new = mag_w(acc_reg);
    assign mag_b_new = mag_w(opnd_clip);
    assign op_new    = cfc_pkg::decode_op(op_char);

    // One multiply step: add multiplicand on the low bit, shift right
    logic [W:0] mul_sum;
    assign mul_sum = {1'b0, h_reg} + (x_reg[0] ? {1'b0, mag_a_reg} : {(W+1){1'b0}});

    // One restoring divide step: bring in the next dividend bit, trial subtract
    logic [W:0] div_t, div_diff;
    logic       div_ge;
    assign div_t    = {h_reg, x_reg[QW-1]};
    assign div_ge   = div_t >= {1'b0, mag_b_reg};
    assign div_diff = div_t - {1'b0, mag_b_reg};

    always_comb
    begin
        h_next = h_reg;
        x_next = x_reg;
        if (cmd.load)
        begin
            h_next = '0;
            if (op_new == cfc_pkg::OP_DIV)
                x_next = XW'(mag_a_new) << FRAC_BITS;
            else
                x_next = XW'(mag_b_new);
        end
        else if (cmd.step)
        begin
            if (cmd.kind == cfc_pkg::RES_DIV)
            begin
                h_next = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
                x_next = {x_reg[XW-2:0], div_ge};
            end
            else
            begin
                h_next = mul_sum[W:1];
                x_next = {mul_sum[0], x_reg[XW-1:1]};
            end
        end
    end

    // Multiply/divide result: magnitude back to signed, saturating
    logic [2*W-1:0] prod, prod_sh;
    logic [XW-1:0]  md_mag;
    logic [W-1:0]   md_lim, md_r;
    logic           md_over;

    assign prod    = {h_reg, x_reg[XW-1 -: W]};
    assign prod_sh = prod >> FRAC_BITS;
    assign md_mag  = (cmd.kind == cfc_pkg::RES_MUL) ? XW'(prod_sh) : XW'(x_reg[QW-1:0]);
    assign md_lim  = neg_reg ? MIN_W : MAX_W;
    assign md_over = (|md_mag[XW-1:W]) || (md_mag[W-1:0] > md_lim);
    assign md_r    = md_over ? md_lim
                   : (neg_reg ? (~md_mag[W-1:0] + W'(1)) : md_mag[W-1:0]);

    // Add/subtract one bit wider, then clip
    logic [W:0]   add_s;
    logic         add_over;
    logic [W-1:0] add_r;

    assign add_s    = (cmd.kind == cfc_pkg::RES_SUB)
                    ? ({acc_reg[W-1], acc_reg} - {opnd_reg[W-1], opnd_reg})
                    : ({acc_reg[W-1], acc_reg} + {opnd_reg[W-1], opnd_reg});
    assign add_over = add_s[W] != add_s[W-1];
    assign add_r    = add_over ? (add_s[W] ? MIN_W : MAX_W) : add_s[W-1:0];

    // Retire the word
    logic signed [W-1:0] acc_s;
    logic signed [63:0]  acc_64;
    logic [2:0]          st_fin;

    always_comb
    begin
        acc_next     = acc_reg;
        aborted_next = aborted_reg;
        st_fin       = cfc_pkg::ST_IGNORED;
        case (cmd.kind)
            cfc_pkg::RES_START:
            begin
                acc_next     = opnd_reg;
                aborted_next = 1'b0;
                st_fin       = sat_in_reg ? cfc_pkg::ST_SAT : cfc_pkg::ST_OK;
            end
            cfc_pkg::RES_IGNORE:
                st_fin = cfc_pkg::ST_IGNORED;
            cfc_pkg::RES_BADOP:
            begin
                aborted_next = 1'b1;
                st_fin       = cfc_pkg::ST_BADOP;
            end
            cfc_pkg::RES_DIVZ:
            begin
                aborted_next = 1'b1;
                st_fin       = cfc_pkg::ST_DIVZ;
            end
            cfc_pkg::RES_ADD, cfc_pkg::RES_SUB:
            begin
                acc_next = add_r;
                st_fin   = (sat_in_reg || add_over) ? cfc_pkg::ST_SAT : cfc_pkg::ST_OK;
            end
            cfc_pkg::RES_MUL, cfc_pkg::RES_DIV:
            begin
                acc_next = md_r;
                st_fin   = (sat_in_reg || md_over) ? cfc_pkg::ST_SAT : cfc_pkg::ST_OK;
            end
            default:
                st_fin = cfc_pkg::ST_IGNORED;
        endcase
        if (!cmd.fin)
        begin
            acc_next     = acc_reg;
            aborted_next = aborted_reg;
        end
    end

    // Outgoing value: word sign-extended, low 32 bits kept
    assign acc_s       = acc_next;
    assign acc_64      = 64'(acc_s);
    assign value_next  = cmd.fin ? acc_64[31:0] : value_reg;
    assign status_next = cmd.fin ? st_fin : status_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            aborted_reg <= aborted_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_start_reg <= !action;
            op_reg       <= op_new;
            opnd_reg     <= opnd_clip;
            sat_in_reg   <= in_hi || in_lo;
            zero_reg     <= operand == 32'sd0;
            neg_reg      <= acc_reg[W-1] ^ opnd_clip[W-1];
            mag_a_reg    <= mag_a_new;
            mag_b_reg    <= mag_b_new;
        end
        h_reg      <= h_next;
        x_reg      <= x_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign stat.is_start  = is_start_reg;
    assign stat.aborted   = aborted_reg;
    assign stat.op        = op_reg;
    assign stat.opnd_zero = zero_reg;

    assign value  = value_reg;
    assign status = status_reg;

endmodule

/* src/cfc_ctrl.sv */
// Controller: sequences capture, decode, bit iterations and result hand-off.
`include "chained_four_op_calculator_defines.svh"

module cfc_ctrl #(
    parameter int WORD_BITS = cfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cfc_pkg::dp_stat_t stat,
    output cfc_pkg::dp_cmd_t  cmd
);

    localparam int QW = WORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(WORD_BITS - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ITER,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    cfc_pkg::res_kind_t   kind_reg, kind_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    cfc_pkg::res_kind_t   exec_kind;
    logic                 load, step, fin, slot_free;

    assign in_ready  = state_reg == S_IDLE;
    assign load      = in_valid && in_ready;
    assign step      = state_reg == S_ITER;
    assign slot_free = !out_valid_reg || out_ready;
    assign fin       = (state_reg == S_FIN) && slot_free;

    // Classify the captured word
    always_comb
    begin
        if (stat.is_start)
            exec_kind = cfc_pkg::RES_START;
        else if (stat.aborted)
            exec_kind = cfc_pkg::RES_IGNORE;
        else
        begin
            case (stat.op)
                cfc_pkg::OP_ADD: exec_kind = cfc_pkg::RES_ADD;
                cfc_pkg::OP_SUB: exec_kind = cfc_pkg::RES_SUB;
                cfc_pkg::OP_MUL: exec_kind = cfc_pkg::RES_MUL;
                cfc_pkg::OP_DIV: exec_kind = stat.opnd_zero ? cfc_pkg::RES_DIVZ
                                                            : cfc_pkg::RES_DIV;
                default:         exec_kind = cfc_pkg::RES_BADOP;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        out_valid_next = fin ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        case (state_reg)
            S_IDLE:
                if (load)
                    state_next = S_EXEC;
            S_EXEC:
            begin
                kind_next = exec_kind;
                if (exec_kind == cfc_pkg::RES_MUL)
                begin
                    cnt_next   = MUL_LAST;
                    state_next = S_ITER;
                end
                else if (exec_kind == cfc_pkg::RES_DIV)
                begin
                    cnt_next   = DIV_LAST;
                    state_next = S_ITER;
                end
                else
                    state_next = S_FIN;
            end
            S_ITER:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= cfc_pkg::RES_IGNORE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd.load  = load;
    assign cmd.step  = step;
    assign cmd.fin   = fin;
    assign cmd.kind  = kind_reg;

    // Checks
    `CFC_ASSERT_IMP(a_step_kind, step, kind_reg == cfc_pkg::RES_MUL || kind_reg == cfc_pkg::RES_DIV, "iteration step outside multiply or divide")
    `CFC_ASSERT_NXT(a_fin_valid, fin, out_valid_reg, "retired word not presented")
    `CFC_ASSERT_NXT(a_load_exec, load, state_reg == S_EXEC, "captured word not decoded next")
    `CFC_ASSERT_NXT(a_iter_end, state_reg == S_ITER && cnt_reg == '0, state_reg == S_FIN, "iteration count overran")
    `CFC_ASSERT_NXT(a_fin_hold, state_reg == S_FIN && !slot_free, state_reg == S_FIN, "result dropped while output busy")

endmodule

/* src/chained_four_op_calculator.sv */
// Chained four-operation calculator: signed fixed-point accumulator with + - * /.
// One result word per input word. A start word loads the accumulator and clears
// the abort flag; an apply word does accumulator op operand with saturation.
// From acceptance a word is captured and decoded, then iterated for multiply
// (shift-add, one multiplier bit per cycle) or divide (restoring, one quotient
// bit per cycle), then loaded into the output register; default format Q16.16.
// One word is in work at a time; the next is accepted as soon as the previous
// result is loaded into the output register, even if it has not been taken yet.
module chained_four_op_calculator #(
    parameter int WORD_BITS = cfc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cfc_in_if.sink    item,
    cfc_out_if.source result
);

    cfc_pkg::dp_cmd_t  cmd;
    cfc_pkg::dp_stat_t stat;

    cfc_ctrl #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfc_dp #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .action  (item.action),
        .op_char (item.op_char),
        .operand (item.operand),
        .value   (result.value),
        .status  (result.status)
    );

endmodule

/* tb/calc_checker.sv */
// Result checker for the chained calculator: predicts each result word and compares it.
module calc_checker
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfc_in_if           item_ch,
    cfc_out_if          res_ch,
    output int unsigned pending,
    output int unsigned fail_count
);

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [63:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WORD_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } calc_word_t;

    // Shadow copy of the block state
    logic signed [31:0] acc;
    logic               abort_flag;

    calc_word_t expected_words[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch, %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Compute the result word of one accepted input word and advance the state
    function automatic calc_word_t step_calc(input logic act, input logic [7:0] opc,
                                             input logic signed [31:0] opnd);
        calc_word_t r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] s;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mag;
        logic [63:0] lim;
        logic neg;
        logic use_mag;
        a = {{32{acc[31]}}, acc};
        b = {{32{opnd[31]}}, opnd};
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        neg = a[63] ^ b[63];
        mag = '0;
        use_mag = 1'b0;
        r.status = ST_OK;
        if (!act) begin
            acc = opnd;
            abort_flag = 1'b0;
        end else if (abort_flag) begin
            r.status = ST_IGNORED;
        end else begin
            case (opc)
                CH_ADD, CH_SUB: begin
                    s = (opc == CH_ADD) ? a + b : a - b;
                    if (s > WORD_MAX) begin
                        acc = WORD_MAX[31:0];
                        r.status = ST_SAT;
                    end else if (s < WORD_MIN) begin
                        acc = WORD_MIN[31:0];
                        r.status = ST_SAT;
                    end else begin
                        acc = s[31:0];
                    end
                end
                CH_MUL: begin
                    mag = (ma * mb) >> FRAC;
                    use_mag = 1'b1;
                end
                CH_DIV: begin
                    if (opnd == 0) begin
                        abort_flag = 1'b1;
                        r.status = ST_DIVZ;
                    end else begin
                        mag = (ma << FRAC) / mb;
                        use_mag = 1'b1;
                    end
                end
                default: begin
                    abort_flag = 1'b1;
                    r.status = ST_BADOP;
                end
            endcase
            // Magnitude result: apply sign, saturate outside the word range
            if (use_mag) begin
                lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                if (mag > lim) begin
                    acc = neg ? WORD_MIN[31:0] : WORD_MAX[31:0];
                    r.status = ST_SAT;
                end else begin
                    acc = neg ? -mag[31:0] : mag[31:0];
                end
            end
        end
        r.value = acc;
        return r;
    endfunction

    // Compare finished words first, then record the newly accepted one
    always @(posedge clk or negedge rst_n) begin
        calc_word_t want;
        if (!rst_n) begin
            acc        = '0;
            abort_flag = 1'b0;
            fail_count = 0;
            expected_words.delete();
            pending <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing pending", res_ch.value, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (res_ch.value !== want.value)
                        report_mismatch("value", res_ch.value, want.value);
                    if (res_ch.status !== want.status)
                        report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                end
            end
            if (item_ch.valid && item_ch.ready)
                expected_words.push_back(step_calc(item_ch.action, item_ch.op_char,
                                                   item_ch.operand));
            pending <= expected_words.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for the chained calculator: clock, reset, stimulus and verdict.
module tb;
    import cfc_pkg::*;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;
    localparam int   RANDOM_WORDS = 650;
    localparam int   QUIET_LIMIT  = 4000;
    localparam int   TAIL_CYCLES  = 60;

    logic        clk;
    logic        rst_n;
    bit          no_idle;
    int unsigned pending;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    cfc_in_if  item_ch ();
    cfc_out_if res_ch ();

    chained_four_op_calculator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    calc_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .res_ch     (res_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Operand mix: corners, full range, and small values that keep chains alive
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    5: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    // Present one word and hold it until accepted; valid stays high afterwards
    task automatic send_word(input logic act, input logic [7:0] opc, input logic [31:0] opnd);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= act;
        item_ch.op_char <= opc;
        item_ch.operand <= opnd;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result word
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random back-pressure, none while no_idle is set
    initial begin : sink_side
        int hold;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                hold = 1 + idle_len();
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("chained_four_op_calculator regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int   counted;
        int   len;
        bit   drained;
        logic [7:0]  opc;
        logic [31:0] opnd;
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_START;
        item_ch.op_char = 8'h00;
        item_ch.operand = '0;
        no_idle         = 1'b0;
        counted         = 0;
        drained         = 1'b0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: apply on the reset accumulator
        send_word(ACT_APPLY, CH_ADD, 32'h0001_0000);
        // Add and subtract saturation at both ends
        send_word(ACT_START, CH_ADD, 32'h7FFF_FFFF);
        send_word(ACT_APPLY, CH_ADD, 32'h0000_0001);
        send_word(ACT_START, CH_SUB, 32'h8000_0000);
        send_word(ACT_APPLY, CH_SUB, 32'h0000_0001);
        send_word(ACT_START, 8'hFF, 32'hFFFF_FFFF);
        send_word(ACT_APPLY, CH_SUB, 32'h8000_0000);
        // Ordinary multiply and divide, signs mixed
        send_word(ACT_START, CH_MUL, 32'h0003_0000);
        send_word(ACT_APPLY, CH_MUL, 32'h0002_0000);
        send_word(ACT_APPLY, CH_MUL, 32'hFFFF_0000);
        send_word(ACT_APPLY, CH_DIV, 32'h0004_0000);
        // Divide by zero, then an ignored apply
        send_word(ACT_APPLY, CH_DIV, 32'h0000_0000);
        send_word(ACT_APPLY, CH_ADD, 32'h0000_0001);
        // Most negative word times -1 and divided by 1
        send_word(ACT_START, CH_DIV, 32'h8000_0000);
        send_word(ACT_APPLY, CH_MUL, 32'hFFFF_0000);
        send_word(ACT_START, CH_DIV, 32'h8000_0000);
        send_word(ACT_APPLY, CH_DIV, 32'h0001_0000);
        // Product overflow, then a large quotient that still fits
        send_word(ACT_START, CH_MUL, 32'h7FFF_FFFF);
        send_word(ACT_APPLY, CH_MUL, 32'h7FFF_FFFF);
        send_word(ACT_START, CH_DIV, 32'h0001_0000);
        send_word(ACT_APPLY, CH_DIV, 32'h0000_0003);
        // Truncation toward zero
        send_word(ACT_START, CH_DIV, 32'h0000_0001);
        send_word(ACT_APPLY, CH_DIV, 32'h7FFF_FFFF);
        send_word(ACT_START, CH_MUL, 32'hFFFF_FFFF);
        send_word(ACT_APPLY, CH_MUL, 32'h0000_8000);
        // Unknown operators on start and apply words, and an apply ignored after an abort
        send_word(ACT_START, 8'h00, 32'h0000_0000);
        send_word(ACT_APPLY, 8'h00, 32'h0001_0000);
        send_word(ACT_APPLY, 8'hFF, 32'hFFFF_FFFF);
        send_word(ACT_START, 8'h25, 32'h0002_0000);
        send_word(ACT_APPLY, 8'h25, 32'h0001_0000);

        // Random chains: a start, then a few applies, with some noise mixed in
        while (counted < RANDOM_WORDS) begin
            no_idle = (counted >= 150 && counted < 250);
            if (!drained && counted >= 325) begin
                drain_results();
                drained = 1'b1;
            end
            if ($urandom_range(0, 19) != 0) begin
                send_word(ACT_START, 8'($urandom_range(0, 255)), rand_operand());
                counted++;
            end
            len = $urandom_range(1, 8);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0) begin
                    opc = 8'($urandom_range(0, 255));
                end else begin
                    case ($urandom_range(0, 3))
                        0: opc = CH_ADD;
                        1: opc = CH_SUB;
                        2: opc = CH_MUL;
                        default: opc = CH_DIV;
                    endcase
                end
                opnd = rand_operand();
                counted++;
                send_word(ACT_APPLY, opc, opnd);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("chained_four_op_calculator regression: pass");
        else
            $display("chained_four_op_calculator regression: fail");
        $finish;
    end

endmodule
